@@ hdl/gepc_pkg.sv @@
// shared types, constants and helpers for the grid exit path counter
// no dependencies; used by gepc_cell and grid_exit_path_counter
`default_nettype none

package gepc_pkg;

  localparam int unsigned CNT_W = 30;
  localparam logic [CNT_W-1:0] PRIME = 30'd1000000007;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_FETCH,
    S_DONE
  } gepc_state_t;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic rd_en;    // read the column store
    logic rd_half;  // half holding the previous layer
    logic first;    // building layer 1: previous layer is all zero
    logic a_top;    // row in the sum stage is the top row
    logic a_bot;    // row in the sum stage is the bottom row
    logic wr_en;    // write the finished count
    logic wr_half;  // half receiving the new layer
  } gepc_ctrl_t;

  // modular add of two reduced values
  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/gepc_cell.sv @@
// one grid column: two-layer count store, row window and modular sum
// depends on gepc_pkg
`default_nettype none

module gepc_cell #(
  parameter int MAX_DIM = 64,
  parameter int COL_IDX = 0,
  parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int RW      = $clog2(MAX_DIM + 1)
) (
  input  wire logic                            clk,
  input  wire gepc_pkg::gepc_ctrl_t            ctrl,
  input  wire logic [AW-1:0]                   rd_addr,
  input  wire logic [AW-1:0]                   wr_addr,
  input  wire logic [RW-1:0]                   cols,
  input  wire logic [gepc_pkg::CNT_W-1:0]      left_in,
  input  wire logic [gepc_pkg::CNT_W-1:0]      right_in,
  output logic      [gepc_pkg::CNT_W-1:0]      mid_out,
  output logic      [gepc_pkg::CNT_W-1:0]      rd_out
);

  localparam int DW = gepc_pkg::CNT_W;

  logic [DW-1:0] mem [2**(AW+1)];
  logic [DW-1:0] rd_q_r;
  logic [DW-1:0] mid_r;
  logic [DW-1:0] up_r;
  logic [DW-1:0] ud_r;
  logic [DW-1:0] lr_r;
  logic [DW-1:0] rd_m;
  logic [DW-1:0] up_v;
  logic [DW-1:0] dn_v;
  logic [DW-1:0] lf_v;
  logic [DW-1:0] rt_v;
  logic          right_edge;

  // column store, one read and one write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[{ctrl.wr_half, wr_addr}] <= gepc_pkg::add_mod(ud_r, lr_r);
    end
    if (ctrl.rd_en) begin
      rd_q_r <= mem[{ctrl.rd_half, rd_addr}];
    end
  end

  // previous layer is zero while layer 1 is built
  assign rd_m = ctrl.first ? '0 : rd_q_r;

  // window over rows r-1 and r of this column
  always_ff @(posedge clk) begin
    mid_r <= rd_m;
    up_r  <= mid_r;
  end

  assign right_edge = (cols <= RW'(COL_IDX + 1));

  // neighbors, an off-grid neighbor counts one walk
  always_comb begin
    up_v = ctrl.a_top ? DW'(1) : up_r;
    dn_v = ctrl.a_bot ? DW'(1) : rd_m;
    lf_v = (COL_IDX == 0) ? DW'(1) : left_in;
    rt_v = right_edge ? DW'(1) : right_in;
  end

  // pair sums, finished in the write stage
  always_ff @(posedge clk) begin
    ud_r <= gepc_pkg::add_mod(up_v, dn_v);
    lr_r <= gepc_pkg::add_mod(lf_v, rt_v);
  end

  assign mid_out = mid_r;
  assign rd_out  = rd_q_r;

endmodule

`default_nettype wire

@@ hdl/grid_exit_path_counter.sv @@
// top level: beat handshake, layer sequencer and the row of column cells
// depends on gepc_pkg and gepc_cell
`default_nettype none

// Counts the walks of at most move_budget steps from a start cell that leave
// a grid_rows x grid_cols grid, modulo 1000000007. One column cell per grid
// column updates all columns of a row together, one row per cycle, and each
// layer is one sweep of the rows through the column stores. A query with the
// start inside the grid runs move_budget layers and then fetches the result
// from the start cell's column store; a start outside the grid or a zero
// budget is answered without a sweep. One query is in work at a time; a
// finished result waits in the output register.
module grid_exit_path_counter #(
  parameter int MAX_DIM   = 64,
  parameter int MAX_STEPS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // grid_rows[6:0], grid_cols[13:7], move_budget[20:14], start_row[26:21],
  // start_col[32:27], zero pad [39:33]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // path_count[29:0], zero pad [31:30]
  output logic      [31:0] out_tdata
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int RW = $clog2(MAX_DIM + 1);
  localparam int PW = $clog2(MAX_DIM + 3);
  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int CW = (RW > 7) ? RW : 7;
  localparam int BW = (SW > 7) ? SW : 7;
  localparam int DW = gepc_pkg::CNT_W;

  gepc_pkg::gepc_state_t state_r, state_nxt;
  gepc_pkg::gepc_ctrl_t  ctrl;

  logic [RW-1:0] rows_r;
  logic [RW-1:0] cols_r;
  logic [SW-1:0] budget_r;
  logic [AW-1:0] sr_r;
  logic [AW-1:0] sc_r;
  logic          one_r;
  logic          zero_r;
  logic [PW-1:0] p_r;
  logic [SW-1:0] k_r;
  logic          wr_en_r;
  logic          wr_half_r;
  logic [AW-1:0] wr_addr_r;
  logic          out_valid_r;
  logic [DW-1:0] out_cnt_r;

  logic [CW-1:0] rows_sat;
  logic [CW-1:0] cols_sat;
  logic [BW-1:0] budget_sat;
  logic          outside;
  logic          in_beat;
  logic          layer_end;
  logic          a_vld;
  logic          out_load;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] result;

  logic [DW-1:0] mid_all [MAX_DIM];
  logic [DW-1:0] rd_all  [MAX_DIM];

  // input saturation and the off-grid check
  always_comb begin
    rows_sat = (CW'(in_tdata[6:0]) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(in_tdata[6:0]);
    cols_sat = (CW'(in_tdata[13:7]) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(in_tdata[13:7]);
    budget_sat = (BW'(in_tdata[20:14]) > BW'(MAX_STEPS)) ? BW'(MAX_STEPS)
                                                          : BW'(in_tdata[20:14]);
    outside = (CW'(in_tdata[26:21]) >= rows_sat) || (CW'(in_tdata[32:27]) >= cols_sat);
  end

  assign in_beat   = in_tvalid && in_tready;
  assign layer_end = (p_r == PW'(rows_r) + PW'(2));
  assign out_load  = (state_r == gepc_pkg::S_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gepc_pkg::S_IDLE: begin
        if (in_beat) begin
          if (outside || (budget_sat == '0)) begin
            state_nxt = gepc_pkg::S_DONE;
          end else begin
            state_nxt = gepc_pkg::S_RUN;
          end
        end
      end
      gepc_pkg::S_RUN: begin
        if (layer_end && (k_r == budget_r)) begin
          state_nxt = gepc_pkg::S_FETCH;
        end
      end
      gepc_pkg::S_FETCH: begin
        state_nxt = gepc_pkg::S_DONE;
      end
      gepc_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = gepc_pkg::S_IDLE;
        end
      end
      default: state_nxt = gepc_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready    = 1'b0;
    ctrl         = '0;
    rd_addr      = p_r[AW-1:0];
    a_vld        = 1'b0;
    ctrl.first   = (k_r == SW'(1));
    ctrl.wr_en   = wr_en_r;
    ctrl.wr_half = wr_half_r;
    ctrl.rd_half = ~k_r[0];
    ctrl.first   = (k_r == SW'(1));
    unique case (state_r)
      gepc_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      gepc_pkg::S_RUN: begin
        ctrl.rd_en = (p_r < PW'(rows_r));
        a_vld      = (p_r >= PW'(2)) && (p_r < PW'(rows_r) + PW'(2));
        ctrl.a_top = (p_r == PW'(2));
        ctrl.a_bot = (p_r == PW'(rows_r) + PW'(1));
      end
      gepc_pkg::S_FETCH: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_half = budget_r[0];
        ctrl.first   = 1'b0;
        rd_addr      = sr_r;
      end
      gepc_pkg::S_DONE: begin
        ctrl.first = 1'b0;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // state, query registers and layer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gepc_pkg::S_IDLE;
      p_r     <= '0;
      k_r     <= '0;
      wr_en_r <= 1'b0;
      one_r   <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wr_en_r <= a_vld;
      if (in_beat) begin
        one_r  <= outside;
        zero_r <= !outside && (budget_sat == '0);
        p_r    <= '0;
        k_r    <= SW'(1);
      end else if (state_r == gepc_pkg::S_RUN) begin
        if (layer_end) begin
          p_r <= '0;
          k_r <= k_r + SW'(1);
        end else begin
          p_r <= p_r + PW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      rows_r   <= RW'(rows_sat);
      cols_r   <= RW'(cols_sat);
      budget_r <= SW'(budget_sat);
      sr_r     <= AW'(in_tdata[26:21]);
      sc_r     <= AW'(in_tdata[32:27]);
    end
    wr_half_r <= k_r[0];
    wr_addr_r <= AW'(p_r - PW'(2));
  end

  // row of column cells, each hands its row value to both neighbors
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
    logic [DW-1:0] left_v;
    logic [DW-1:0] right_v;
    if (c == 0) begin : g_l0
      assign left_v = '0;
    end else begin : g_l
      assign left_v = mid_all[c-1];
    end
    if (c == MAX_DIM - 1) begin : g_rn
      assign right_v = '0;
    end else begin : g_r
      assign right_v = mid_all[c+1];
    end
    gepc_cell #(
      .MAX_DIM (MAX_DIM),
      .COL_IDX (c)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr_r),
      .cols     (cols_r),
      .left_in  (left_v),
      .right_in (right_v),
      .mid_out  (mid_all[c]),
      .rd_out   (rd_all[c])
    );
  end

  assign result = one_r ? DW'(1) : (zero_r ? '0 : rd_all[sc_r]);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cnt_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r};

  // store writes only come from a layer sweep
  a_wr_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en |-> (state_r == gepc_pkg::S_RUN))
    else $error("column store written outside a layer sweep");

  // row counter stays within one layer
  a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gepc_pkg::S_RUN) |-> (p_r <= PW'(rows_r) + PW'(2)))
    else $error("row counter ran past the layer");

  // both shortcut results never flagged together
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    !(one_r && zero_r))
    else $error("conflicting shortcut results");

  // fetch follows the last layer
  a_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gepc_pkg::S_FETCH) |-> ($past(state_r) == gepc_pkg::S_RUN))
    else $error("result fetch without a finished sweep");

endmodule

`default_nettype wire
